[hw/rtl/gaq_pkg.sv]
// gas alarm qualifier package: severity, opcode and register index codes,
// the result record and the fixed widths shared by the rtl files
// no dependencies
`timescale 1ns / 1ps

package gaq_pkg;

  // number of sensor channels and width of a channel index
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned CH_IDX_W = 2;

  // confirm counter
  localparam int unsigned CNT_W     = 8;
  localparam logic [7:0]  COUNT_MAX = 8'd255;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] LEVEL_RESET   = 16'hFFFF;
  localparam logic [7:0]  CONFIRM_RESET = 8'd3;
  localparam logic [7:0]  GRACE_RESET   = 8'd10;

  // master-side data width
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    SEV_NORM = 2'd0,
    SEV_WARN = 2'd1,
    SEV_CRIT = 2'd2
  } sev_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_RECAL  = 1'b1
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WARN0   = 4'd0,
    CFG_CRIT0   = 4'd1,
    CFG_WARN1   = 4'd2,
    CFG_CRIT1   = 4'd3,
    CFG_WARN2   = 4'd4,
    CFG_CRIT2   = 4'd5,
    CFG_CONFIRM = 4'd6,
    CFG_GRACE   = 4'd7
  } cfg_idx_e;

  // buzzer patterns
  typedef enum logic [1:0] {
    BUZZ_OFF  = 2'd0,
    BUZZ_WARN = 2'd1,
    BUZZ_CRIT = 2'd2
  } buzz_e;

  // alert qualification settings
  typedef struct packed {
    logic [CNT_W-1:0] confirm_cycles;
    logic [CNT_W-1:0] grace_cycles;
  } cfg_ctrl_t;

  // one result record, last member in the lowest bits
  typedef struct packed {
    logic                invert_display;
    logic                voice_critical;
    buzz_e               buzzer_mode;
    logic                alert_confirmed;
    logic [CH_IDX_W-1:0] worst_channel;
    sev_e                worst_level;
    sev_e                level_ch2;
    sev_e                level_ch1;
    sev_e                level_ch0;
  } result_t;

endpackage

[hw/rtl/multi_channel_gas_alarm_qualifier.sv]
// gas alarm qualifier top level: input register, classifiers, qualifier
// state and result register with stream handshakes
// depends on gaq_pkg, gaq_cfg_regs, gaq_classify, gaq_qualifier
//
//  channel   direction  handshake                        payload
//  s_axis    in         s_axis_tvalid_i/s_axis_tready_o  tdata ppm x3, tuser opcode
//  m_axis    out        m_axis_tvalid_o/m_axis_tready_i  tdata result record
//  cfg       in         cfg_valid_i/cfg_ready_o          cfg_addr_i, cfg_data_i
//
// one item per cycle unless m_axis stalls: a transaction lands in the input
// register, the classifiers and the qualifier work on it combinationally into the result register
// m_axis valid rises when the result register takes the item from the input register
// a recalibration transaction updates grace and produces no result
// a stall on m_axis holds the result register; the input register still takes
// recalibrations and s_axis stays ready while the result moves on
// reset is asynchronous, no clearing pass; cfg is always ready
`timescale 1ns / 1ps

module multi_channel_gas_alarm_qualifier #(
  parameter int unsigned PPM_WIDTH = 16,
  localparam int unsigned InTdataW = ((gaq_pkg::NUM_CH * PPM_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // fields from bit 0: ppm_ch0, ppm_ch1, ppm_ch2, zero fill
  input  logic [InTdataW-1:0]                 s_axis_tdata_i,
  // fields from bit 0: opcode
  input  logic                                s_axis_tuser_i,
  // master side
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // fields from bit 0: level_ch0, level_ch1, level_ch2, worst_level,
  // worst_channel, alert_confirmed, buzzer_mode, voice_critical,
  // invert_display, zero fill
  output logic [gaq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gaq_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [gaq_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import gaq_pkg::*;

  logic [NUM_CH-1:0][PPM_WIDTH-1:0] warn_lvl, crit_lvl;
  cfg_ctrl_t                        ctrl;

  logic                             in_valid_q, in_valid_d;
  op_e                              in_op_q;
  logic [NUM_CH-1:0][PPM_WIDTH-1:0] in_ppm_q;
  logic                             in_fire;
  logic                             advance;
  logic                             is_recal;

  sev_e [NUM_CH-1:0]                level;
  result_t                          result;
  result_t                          out_res_q;
  logic                             out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  gaq_cfg_regs #(
    .PPM_WIDTH (PPM_WIDTH)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .warn_lvl_o  (warn_lvl),
    .crit_lvl_o  (crit_lvl),
    .ctrl_o      (ctrl)
  );

  // handshake: the input register moves on when its item is a recalibration or has a free result slot
  assign is_recal        = (in_op_q == OP_RECAL);
  assign advance         = in_valid_q && (is_recal || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_op_q <= op_e'(s_axis_tuser_i);
      for (int i = 0; i < NUM_CH; i++) begin
        in_ppm_q[i] <= s_axis_tdata_i[i*PPM_WIDTH +: PPM_WIDTH];
      end
    end
  end

  // channel classifiers
  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    gaq_classify #(
      .PPM_WIDTH (PPM_WIDTH)
    ) u_classify (
      .ppm_i      (in_ppm_q[g]),
      .warn_lvl_i (warn_lvl[g]),
      .crit_lvl_i (crit_lvl[g]),
      .level_o    (level[g])
    );
  end

  gaq_qualifier u_qualifier (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .recal_i  (is_recal),
    .level_i  (level),
    .ctrl_i   (ctrl),
    .result_o (result)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && !is_recal) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !is_recal) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_res_q);

endmodule

[hw/rtl/gaq_cfg_regs.sv]
// gas alarm qualifier configuration registers: thresholds per channel,
// confirm length and grace length
// depends on gaq_pkg
`timescale 1ns / 1ps

module gaq_cfg_regs #(
  parameter int unsigned PPM_WIDTH = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              cfg_valid_i,
  input  logic [gaq_pkg::CFG_ADDR_W-1:0]                    cfg_addr_i,
  input  logic [gaq_pkg::CFG_DATA_W-1:0]                    cfg_data_i,
  output logic [gaq_pkg::NUM_CH-1:0][PPM_WIDTH-1:0]         warn_lvl_o,
  output logic [gaq_pkg::NUM_CH-1:0][PPM_WIDTH-1:0]         crit_lvl_o,
  output gaq_pkg::cfg_ctrl_t                                ctrl_o
);
  import gaq_pkg::*;

  logic [NUM_CH-1:0][PPM_WIDTH-1:0] warn_q, warn_d;
  logic [NUM_CH-1:0][PPM_WIDTH-1:0] crit_q, crit_d;
  cfg_ctrl_t                        ctrl_q, ctrl_d;
  logic [PPM_WIDTH-1:0]             lvl_val;

  // thresholds take the low 16 bits, fitted to the reading width
  assign lvl_val = PPM_WIDTH'(cfg_data_i);

  // register write decode, unknown indexes are dropped
  always_comb begin
    warn_d = warn_q;
    crit_d = crit_q;
    ctrl_d = ctrl_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_WARN0:   warn_d[0] = lvl_val;
        CFG_CRIT0:   crit_d[0] = lvl_val;
        CFG_WARN1:   warn_d[1] = lvl_val;
        CFG_CRIT1:   crit_d[1] = lvl_val;
        CFG_WARN2:   warn_d[2] = lvl_val;
        CFG_CRIT2:   crit_d[2] = lvl_val;
        CFG_CONFIRM: ctrl_d.confirm_cycles = cfg_data_i[CNT_W-1:0];
        CFG_GRACE:   ctrl_d.grace_cycles = cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        warn_q[i] <= PPM_WIDTH'(LEVEL_RESET);
        crit_q[i] <= PPM_WIDTH'(LEVEL_RESET);
      end
      ctrl_q.confirm_cycles <= CONFIRM_RESET;
      ctrl_q.grace_cycles   <= GRACE_RESET;
    end else begin
      warn_q <= warn_d;
      crit_q <= crit_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign warn_lvl_o = warn_q;
  assign crit_lvl_o = crit_q;
  assign ctrl_o     = ctrl_q;

endmodule

[hw/rtl/gaq_classify.sv]
// gas alarm qualifier channel classifier: one reading against its
// warning and critical thresholds, critical tested first
// depends on gaq_pkg
`timescale 1ns / 1ps

module gaq_classify #(
  parameter int unsigned PPM_WIDTH = 16
) (
  input  logic [PPM_WIDTH-1:0] ppm_i,
  input  logic [PPM_WIDTH-1:0] warn_lvl_i,
  input  logic [PPM_WIDTH-1:0] crit_lvl_i,
  output gaq_pkg::sev_e        level_o
);
  import gaq_pkg::*;

  // thresholds are used as given even when warn is above crit
  always_comb begin
    if (ppm_i >= crit_lvl_i) begin
      level_o = SEV_CRIT;
    end else if (ppm_i >= warn_lvl_i) begin
      level_o = SEV_WARN;
    end else begin
      level_o = SEV_NORM;
    end
  end

endmodule

[hw/rtl/gaq_qualifier.sv]
// gas alarm qualifier state and decision: confirm counters, grace
// countdown, worst channel pick and blink phase, builds the result record
// depends on gaq_pkg
`timescale 1ns / 1ps

module gaq_qualifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic                                 recal_i,
  input  gaq_pkg::sev_e [gaq_pkg::NUM_CH-1:0]  level_i,
  input  gaq_pkg::cfg_ctrl_t                   ctrl_i,
  output gaq_pkg::result_t                     result_o
);
  import gaq_pkg::*;

  logic [NUM_CH-1:0][CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0]             grace_q, grace_d;
  logic                         blink_q, blink_d;
  sev_e                         worst;
  logic [CH_IDX_W-1:0]          widx;
  logic                         confirmed;
  logic                         sample;

  assign sample = step_i && !recal_i;

  // per-channel counters clear on normal, otherwise count up to the cap
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (level_i[i] == SEV_NORM) begin
        count_d[i] = '0;
      end else if (count_q[i] == COUNT_MAX) begin
        count_d[i] = count_q[i];
      end else begin
        count_d[i] = count_q[i] + CNT_W'(1);
      end
    end
  end

  // worst channel, lowest index wins a tie
  always_comb begin
    worst = SEV_NORM;
    widx  = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (level_i[i] > worst) begin
        worst = level_i[i];
        widx  = CH_IDX_W'(i);
      end
    end
  end

  assign confirmed = (worst != SEV_NORM) && (count_d[widx] >= ctrl_i.confirm_cycles) &&
                     (grace_q == '0);

  // grace reloads on recalibration and runs down on samples
  always_comb begin
    grace_d = grace_q;
    if (step_i && recal_i) begin
      grace_d = ctrl_i.grace_cycles;
    end else if (sample && grace_q != '0) begin
      grace_d = grace_q - CNT_W'(1);
    end
  end

  assign blink_d = confirmed ? !blink_q : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      grace_q <= GRACE_RESET;
      blink_q <= 1'b0;
    end else begin
      grace_q <= grace_d;
      if (sample) begin
        count_q <= count_d;
        blink_q <= blink_d;
      end
    end
  end

  // result record
  always_comb begin
    result_o.level_ch0       = level_i[0];
    result_o.level_ch1       = level_i[1];
    result_o.level_ch2       = level_i[2];
    result_o.worst_level     = worst;
    result_o.worst_channel   = widx;
    result_o.alert_confirmed = confirmed;
    if (confirmed) begin
      result_o.buzzer_mode = (worst == SEV_CRIT) ? BUZZ_CRIT : BUZZ_WARN;
    end else begin
      result_o.buzzer_mode = BUZZ_OFF;
    end
    result_o.voice_critical  = confirmed && (worst == SEV_CRIT);
    result_o.invert_display  = blink_d;
  end

`ifndef SYNTHESIS
  // no alert while grace is still running
  a_grace_mutes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grace_q != '0) |-> !result_o.alert_confirmed && result_o.buzzer_mode == BUZZ_OFF)
    else $error("alert raised during grace");

  // a sample with grace left takes exactly one off
  a_grace_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample && grace_q != '0) |=> grace_q == $past(grace_q) - CNT_W'(1))
    else $error("grace did not count down");

  // recalibration loads the grace setting
  a_grace_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && recal_i) |=> grace_q == $past(ctrl_i.grace_cycles))
    else $error("grace not reloaded on recalibration");

  // blink phase only stays set across confirmed samples
  a_blink_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample && !confirmed) |=> !blink_q)
    else $error("blink phase not cleared");
`endif

endmodule
